// File: src/dle_pkg.sv
// Shared types, constants and helpers for the loopback descriptor engine.
package dle_pkg;

    localparam int POOL_DEPTH_DEFAULT = 1024;

    localparam int IDX_W    = 28;
    localparam int HANDLE_W = 40;
    localparam int SLOT_W   = 16;
    localparam int WORD_W   = 32;
    localparam int VALID_W  = 16;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_LOG2      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_SIZE = 1'd1;

    localparam logic [4:0]        RING_LOG2_RESET = 5'd12;
    localparam logic [WORD_W-1:0] MAX_FRAME_RESET = 32'd131072;
    localparam logic [WORD_W-1:0] RX_FLAGS_MASK   = 32'hFFFF_FF08;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TX    = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] OUT_LOOPED   = 2'd0;
    localparam logic [1:0] OUT_STARVED  = 2'd1;
    localparam logic [1:0] OUT_OVERSIZE = 2'd2;

    localparam logic RING_READ  = 1'b0;
    localparam logic RING_WRITE = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_TX,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [1:0]          outcome;
        logic [WORD_W-1:0]   flags;
        logic [WORD_W-1:0]   size;
        logic [IDX_W-1:0]    tx_idx;
        logic [HANDLE_W-1:0] tx_hdl;
        logic [IDX_W-1:0]    rx_idx;
        logic [HANDLE_W-1:0] rx_hdl;
    } cmd_t;

    typedef enum logic {
        FE_IDLE,
        FE_HOLD
    } fe_state_t;

    typedef enum logic {
        BE_IDLE,
        BE_SECOND
    } be_state_t;

    function automatic logic [HANDLE_W-1:0] join_handle(input logic [WORD_W-1:0] lo,
                                                        input logic [WORD_W-1:0] hi);
        return {hi, lo[31:28], 4'b0000};
    endfunction

    // next ring position, wrapping at the configured ring size (log2 of 0 or above 16 falls back to 12)
    function automatic logic [SLOT_W-1:0] ring_advance(input logic [SLOT_W-1:0] pos,
                                                       input logic [4:0] log2);
        logic [4:0]        w;
        logic [SLOT_W:0]   mask;
        logic [SLOT_W:0]   nxt;
        w    = (log2 == 5'd0 || log2 > 5'd16) ? RING_LOG2_RESET : log2;
        mask = ({{SLOT_W{1'b0}}, 1'b1} << w) - {{SLOT_W{1'b0}}, 1'b1};
        nxt  = ({1'b0, pos} + {{SLOT_W{1'b0}}, 1'b1}) & mask;
        return nxt[SLOT_W-1:0];
    endfunction

endpackage

// File: src/dle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dle_front.sv
// Front end: takes input words, runs the free-buffer pool and classifies descriptors.
module dle_front #(
    parameter int POOL_DEPTH = dle_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [31:0]                word_a,
    input  logic [31:0]                word_b,
    input  logic [31:0]                word_c,
    input  logic [31:0]                word_d,
    input  logic [31:0]                max_frame_size,
    output logic                       enq_valid,
    output dle_pkg::cmd_t              enq_cmd,
    input  logic                       enq_space
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int FW = $clog2(POOL_DEPTH + 1);
    localparam int EW = dle_pkg::IDX_W + dle_pkg::HANDLE_W;

    dle_pkg::fe_state_t state_reg, state_next;
    logic [FW-1:0]      fill_reg, fill_next;
    dle_pkg::cmd_t      pend_reg;

    logic          accept;
    logic          pool_full;
    logic          pool_empty;
    logic [1:0]    tx_outcome;
    logic          push_en;
    logic          pop_en;
    logic          queue_op;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic [FW-1:0] fill_dec;

    assign accept     = in_valid && in_ready;
    assign pool_full  = (fill_reg == FW'(POOL_DEPTH));
    assign pool_empty = (fill_reg == '0);
    assign fill_dec   = fill_reg - FW'(1);

    always_comb
    begin
        if (pool_empty)
        begin
            tx_outcome = dle_pkg::OUT_STARVED;
        end
        else if (word_b > max_frame_size)
        begin
            // popped buffer would go straight back, so the pool is left alone
            tx_outcome = dle_pkg::OUT_OVERSIZE;
        end
        else
        begin
            tx_outcome = dle_pkg::OUT_LOOPED;
        end
    end

    assign push_en  = accept && (opcode == dle_pkg::OP_PUSH) && !pool_full;
    assign pop_en   = accept && (opcode == dle_pkg::OP_TX)
                      && (tx_outcome == dle_pkg::OUT_LOOPED);
    assign queue_op = accept && ((opcode == dle_pkg::OP_TX) || (opcode == dle_pkg::OP_CLEAR));

    assign ram_wdata = {word_a[dle_pkg::IDX_W-1:0], dle_pkg::join_handle(word_a, word_b)};

    dle_ram #(
        .WIDTH(EW),
        .DEPTH(POOL_DEPTH)
    ) u_pool_ram (
        .clk   (clk),
        .we    (push_en),
        .waddr (fill_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (pop_en),
        .raddr (fill_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && (opcode == dle_pkg::OP_CLEAR))
        begin
            fill_next = '0;
        end
        else if (push_en)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop_en)
        begin
            fill_next = fill_dec;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dle_pkg::FE_IDLE:
            begin
                if (queue_op)
                begin
                    state_next = dle_pkg::FE_HOLD;
                end
            end
            dle_pkg::FE_HOLD:
            begin
                if (enq_space)
                begin
                    state_next = dle_pkg::FE_IDLE;
                end
            end
            default:
            begin
                state_next = dle_pkg::FE_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        enq_valid = 1'b0;
        case (state_reg)
            dle_pkg::FE_IDLE: in_ready  = 1'b1;
            dle_pkg::FE_HOLD: enq_valid = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                enq_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dle_pkg::FE_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_op)
        begin
            pend_reg.kind    <= (opcode == dle_pkg::OP_CLEAR) ? dle_pkg::CMD_CLEAR
                                                              : dle_pkg::CMD_TX;
            pend_reg.outcome <= tx_outcome;
            pend_reg.flags   <= word_a;
            pend_reg.size    <= (tx_outcome == dle_pkg::OUT_LOOPED) ? word_b : '0;
            pend_reg.tx_idx  <= word_c[dle_pkg::IDX_W-1:0];
            pend_reg.tx_hdl  <= dle_pkg::join_handle(word_c, word_d);
            pend_reg.rx_idx  <= '0;
            pend_reg.rx_hdl  <= '0;
        end
    end

    // pool read data lands the cycle after the pop
    always_comb
    begin
        enq_cmd = pend_reg;
        if (pend_reg.outcome == dle_pkg::OUT_LOOPED)
        begin
            enq_cmd.rx_idx = ram_rdata[EW-1:dle_pkg::HANDLE_W];
            enq_cmd.rx_hdl = ram_rdata[dle_pkg::HANDLE_W-1:0];
        end
        else
        begin
            enq_cmd.rx_idx = '0;
            enq_cmd.rx_hdl = '0;
        end
    end

endmodule

// File: src/dle_queue.sv
// Short command queue between the front end and the ring writer.
module dle_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enq_valid,
    input  dle_pkg::cmd_t enq_cmd,
    output logic          enq_space,
    output logic          deq_valid,
    output dle_pkg::cmd_t deq_cmd,
    input  logic          deq_pop
);

    dle_pkg::cmd_t                  entry_reg [dle_pkg::QUEUE_DEPTH];
    logic [dle_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dle_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dle_pkg::QUEUE_CW-1:0]   count_reg, count_next;
    logic                           push;
    logic                           pop;

    assign enq_space = (count_reg != dle_pkg::QUEUE_CW'(dle_pkg::QUEUE_DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_cmd   = entry_reg[rd_ptr_reg];
    assign push      = enq_valid && enq_space;
    assign pop       = deq_pop && deq_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + dle_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + dle_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + dle_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - dle_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule

// File: src/dle_back.sv
// Back end: writes ring entries for queued descriptors and keeps both ring positions.
module dle_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  dle_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic [4:0]    ring_log2,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          ring_select,
    output logic [15:0]   slot,
    output logic [31:0]   entry_word0,
    output logic [27:0]   entry_word1,
    output logic [31:0]   entry_word2,
    output logic [15:0]   entry_word3,
    output logic [39:0]   copy_source,
    output logic [39:0]   copy_target,
    output logic [1:0]    outcome,
    output logic          last
);

    dle_pkg::be_state_t state_reg, state_next;
    dle_pkg::cmd_t      cur_reg;
    logic [15:0]        wpos_reg, rpos_reg;

    logic               out_valid_reg;
    logic               ring_select_reg;
    logic [15:0]        slot_reg;
    logic [31:0]        word0_reg;
    logic [27:0]        word1_reg;
    logic [31:0]        word2_reg;
    logic [15:0]        word3_reg;
    logic [39:0]        src_reg;
    logic [39:0]        tgt_reg;
    logic [1:0]         outcome_reg;
    logic               last_reg;

    logic               slot_free;
    logic               emit;
    logic               clear;
    logic               to_write_ring;
    dle_pkg::cmd_t      src_cmd;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dle_pkg::BE_IDLE:
            begin
                if (q_valid && q_cmd.kind == dle_pkg::CMD_TX && slot_free
                    && q_cmd.outcome == dle_pkg::OUT_LOOPED)
                begin
                    state_next = dle_pkg::BE_SECOND;
                end
            end
            dle_pkg::BE_SECOND:
            begin
                if (slot_free)
                begin
                    state_next = dle_pkg::BE_IDLE;
                end
            end
            default:
            begin
                state_next = dle_pkg::BE_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop         = 1'b0;
        emit          = 1'b0;
        clear         = 1'b0;
        to_write_ring = 1'b0;
        src_cmd       = q_cmd;
        case (state_reg)
            dle_pkg::BE_IDLE:
            begin
                if (q_valid && q_cmd.kind == dle_pkg::CMD_CLEAR)
                begin
                    q_pop = 1'b1;
                    clear = 1'b1;
                end
                else if (q_valid && slot_free)
                begin
                    q_pop         = 1'b1;
                    emit          = 1'b1;
                    to_write_ring = (q_cmd.outcome == dle_pkg::OUT_LOOPED);
                end
            end
            dle_pkg::BE_SECOND:
            begin
                src_cmd = cur_reg;
                emit    = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dle_pkg::BE_IDLE;
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear)
            begin
                wpos_reg <= '0;
                rpos_reg <= '0;
            end
            else if (emit && to_write_ring)
            begin
                wpos_reg <= dle_pkg::ring_advance(wpos_reg, ring_log2);
            end
            else if (emit)
            begin
                rpos_reg <= dle_pkg::ring_advance(rpos_reg, ring_log2);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_cmd;
        end
        if (emit)
        begin
            ring_select_reg <= to_write_ring ? dle_pkg::RING_WRITE : dle_pkg::RING_READ;
            slot_reg        <= to_write_ring ? wpos_reg : rpos_reg;
            word0_reg       <= to_write_ring ? (src_cmd.flags & dle_pkg::RX_FLAGS_MASK)
                                             : src_cmd.flags;
            word1_reg       <= to_write_ring ? src_cmd.rx_idx : src_cmd.tx_idx;
            word2_reg       <= src_cmd.size;
            // chan<<8 | dest; the zero marker sits above the field and reads as zero
            word3_reg       <= {4'b0000, src_cmd.flags[7:4], src_cmd.flags[15:8]};
            src_reg         <= src_cmd.tx_hdl;
            tgt_reg         <= src_cmd.rx_hdl;
            outcome_reg     <= src_cmd.outcome;
            last_reg        <= !to_write_ring;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ring_select = ring_select_reg;
    assign slot        = slot_reg;
    assign entry_word0 = word0_reg;
    assign entry_word1 = word1_reg;
    assign entry_word2 = word2_reg;
    assign entry_word3 = word3_reg;
    assign copy_source = src_reg;
    assign copy_target = tgt_reg;
    assign outcome     = outcome_reg;
    assign last        = last_reg;

endmodule

// File: src/dma_descriptor_loopback_engine.sv
// Top level of the loopback descriptor engine: config registers, front end, queue, back end.
//
// Input channel (in_valid/in_ready) takes one command per handshake: a free-buffer push,
// a transmit descriptor or an engine reset, selected by opcode.
// Output channel (out_valid/out_ready) gives ring entries. A looped-back descriptor
// gives a write ring completion followed by a read ring return (last set on the return);
// a starved or oversize descriptor gives only the read ring return.
// A push leaves in_ready high. A descriptor or engine reset drops in_ready: the pool pop
// out of the pool RAM happens at the accept (registered read), then the front end holds
// and hands the classified word to a two-entry queue, waiting while the queue is full.
// The back end writes one ring entry per cycle while the receiver takes them; the first
// entry passes the front end's hold register, the queue and the back-end output register.
// A stalled receiver holds the output register; the queue keeps the front end running
// until it fills, then in_ready drops.
// Reset empties the pool, zeroes both ring positions and loads ring_log2 = 12 and
// max_frame_size = 131072. Pool RAM contents need no clearing pass.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and are
// meant to happen while the engine is idle.
module dma_descriptor_loopback_engine #(
    parameter int POOL_DEPTH = dle_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [31:0]                       word_a,
    input  logic [31:0]                       word_b,
    input  logic [31:0]                       word_c,
    input  logic [31:0]                       word_d,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ring_select,
    output logic [15:0]                       slot,
    output logic [31:0]                       entry_word0,
    output logic [27:0]                       entry_word1,
    output logic [31:0]                       entry_word2,
    output logic [15:0]                       entry_word3,
    output logic [39:0]                       copy_source,
    output logic [39:0]                       copy_target,
    output logic [1:0]                        outcome,
    output logic                              last,
    input  logic                              cfg_write,
    input  logic [dle_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data
);

    logic [4:0]    ring_log2_reg;
    logic [31:0]   max_frame_size_reg;

    logic          enq_valid;
    logic          enq_space;
    dle_pkg::cmd_t enq_cmd;
    logic          q_valid;
    logic          q_pop;
    dle_pkg::cmd_t q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_log2_reg      <= dle_pkg::RING_LOG2_RESET;
            max_frame_size_reg <= dle_pkg::MAX_FRAME_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dle_pkg::CFG_RING_LOG2:      ring_log2_reg      <= cfg_data[4:0];
                dle_pkg::CFG_MAX_FRAME_SIZE: max_frame_size_reg <= cfg_data;
                default:
                begin
                    ring_log2_reg <= ring_log2_reg;
                end
            endcase
        end
    end

    dle_front #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .word_a         (word_a),
        .word_b         (word_b),
        .word_c         (word_c),
        .word_d         (word_d),
        .max_frame_size (max_frame_size_reg),
        .enq_valid      (enq_valid),
        .enq_cmd        (enq_cmd),
        .enq_space      (enq_space)
    );

    dle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq_valid (enq_valid),
        .enq_cmd   (enq_cmd),
        .enq_space (enq_space),
        .deq_valid (q_valid),
        .deq_cmd   (q_cmd),
        .deq_pop   (q_pop)
    );

    dle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .ring_log2   (ring_log2_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ring_select (ring_select),
        .slot        (slot),
        .entry_word0 (entry_word0),
        .entry_word1 (entry_word1),
        .entry_word2 (entry_word2),
        .entry_word3 (entry_word3),
        .copy_source (copy_source),
        .copy_target (copy_target),
        .outcome     (outcome),
        .last        (last)
    );

endmodule

// File: src/dle_checker.sv
// Port-level checks for the loopback descriptor engine, bound to the top level.
module dle_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              ring_select,
    input  logic [15:0]                       slot,
    input  logic [27:0]                       entry_word1,
    input  logic [31:0]                       entry_word2,
    input  logic [39:0]                       copy_source,
    input  logic [39:0]                       copy_target,
    input  logic [1:0]                        outcome,
    input  logic                              last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(entry_word1)
            && $stable(ring_select) && $stable(last))
        else $error("output word changed while stalled");

    // a write ring completion is never the final entry of its descriptor and comes from a looped-back one
    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ring_select == dle_pkg::RING_WRITE |-> !last
            && outcome == dle_pkg::OUT_LOOPED)
        else $error("write ring entry marked last");

    // starved and oversize descriptors give a lone zero-size return with no target
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome != dle_pkg::OUT_LOOPED |-> last
            && ring_select == dle_pkg::RING_READ && entry_word2 == 32'd0
            && copy_target == 40'd0)
        else $error("rejected descriptor entry malformed");

    // the return follows its completion directly, same copy handles
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && ring_select == dle_pkg::RING_WRITE |=> out_valid
            && ring_select == dle_pkg::RING_READ && last
            && copy_target == $past(copy_target) && copy_source == $past(copy_source))
        else $error("read ring return did not follow completion");

endmodule

bind dma_descriptor_loopback_engine dle_checker u_dle_checker (.*);
